@@ rtl/core/rc4_stream_cipher_core_macros.svh @@
// assertion macros for the rc4 stream cipher core checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef RC4_STREAM_CIPHER_CORE_MACROS_SVH
`define RC4_STREAM_CIPHER_CORE_MACROS_SVH

// consequent in the cycle after the antecedent
`define RC4_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// as RC4_ASSERT_NEXT, but with ##1 added after |=> before the consequent
`define RC4_ASSERT_LATER(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> ##1 (cons)) \
        else $error(msg);

`endif

@@ rtl/core/rc4_pkg.sv @@
// shared types and constants for the rc4 stream cipher core
// no dependencies
package rc4_pkg;

    localparam int BYTE_W     = 8;
    localparam int PERM_DEPTH = 256;
    localparam int KEY_DEPTH  = 255;

    typedef enum logic [1:0] {
        MODE_KEY_LOAD,
        MODE_REKEY,
        MODE_DATA
    } t_mode;

    typedef struct packed {
        logic              clr;
        logic              we;
        logic [BYTE_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [BYTE_W-1:0] raddr;
    } t_perm_req;

endpackage

@@ rtl/core/rc4_perm_mem.sv @@
// permutation memory: 256 x 8 synchronous ram, one write and one read port
// entries without a valid bit read as their own index; uses rc4_pkg
module rc4_perm_mem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rc4_pkg::t_perm_req         i_req,
    output logic [rc4_pkg::BYTE_W-1:0] o_rdata
);
    import rc4_pkg::*;

    logic [BYTE_W-1:0]     r_mem [0:PERM_DEPTH-1];
    logic [PERM_DEPTH-1:0] r_vld_bits;
    logic [BYTE_W-1:0]     r_q;
    logic [BYTE_W-1:0]     r_raddr;
    logic                  r_vld;
    logic                  r_fwd;
    logic [BYTE_W-1:0]     r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_q <= r_mem[i_req.raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_bits <= '0;
        end else if (i_req.clr) begin
            r_vld_bits <= '0;
        end else if (i_req.we) begin
            r_vld_bits[i_req.waddr] <= 1'b1;
        end
    end

    // read side flags, write in the same cycle forwards
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_raddr    <= i_req.raddr;
            r_vld      <= r_vld_bits[i_req.raddr];
            r_fwd      <= i_req.we && (i_req.waddr == i_req.raddr);
            r_fwd_data <= i_req.wdata;
        end
    end

    assign o_rdata = r_fwd ? r_fwd_data : (r_vld ? r_q : r_raddr);

endmodule

@@ rtl/core/rc4_stream_cipher_core.sv @@
// rc4 stream cipher core: a data beat runs ST_D1, ST_D2 and ST_DW; ST_DW waits for a free
// output, registers the result and may accept the next beat; key-load and ignored beats
// stay ready; rekey is busy through ST_K0, then ST_K1, ST_K2, ST_K3 for each schedule step
// synchronous active-low reset: permutation reads as identity at once via valid bits,
// stream indices zero, key_length 1, key store undefined until written
module rc4_stream_cipher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,   // key_length
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [7:0] key_index, [15:8] value
    input  logic [1:0]  s_axis_tuser,  // [1:0] mode
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
    output logic        m_axis_tlast
);
    import rc4_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_D1,
        ST_D2,
        ST_DW,
        ST_K0,
        ST_K1,
        ST_K2,
        ST_K3
    } t_state;

    localparam logic [BYTE_W-1:0] LAST_STEP = BYTE_W'(PERM_DEPTH - 1);
    localparam logic [BYTE_W-1:0] KEY_END   = BYTE_W'(KEY_DEPTH);

    t_state            r_state;
    logic [BYTE_W-1:0] r_i;
    logic [BYTE_W-1:0] r_j;
    logic [BYTE_W-1:0] r_a;
    logic [BYTE_W-1:0] r_t;
    logic [BYTE_W-1:0] r_k;
    logic [BYTE_W-1:0] r_ki;
    logic [BYTE_W-1:0] r_acc;
    logic [BYTE_W-1:0] r_val;
    logic              r_last;
    logic [BYTE_W-1:0] r_key_len;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;
    logic [BYTE_W-1:0] r_key_mem [0:KEY_DEPTH-1];
    logic [BYTE_W-1:0] r_kq;

    t_perm_req         perm_req;
    logic [BYTE_W-1:0] perm_rd;
    logic              in_acc;
    logic              out_free;
    logic [BYTE_W-1:0] key_len_eff;
    logic [BYTE_W-1:0] ki_next;
    logic [BYTE_W-1:0] acc_n;
    logic [BYTE_W-1:0] j_n;
    logic [BYTE_W-1:0] t_n;
    logic [BYTE_W-1:0] ks;
    logic              key_re;
    logic [BYTE_W-1:0] key_raddr;
    logic [BYTE_W-1:0] in_key_index;
    logic [BYTE_W-1:0] in_value;

    rc4_perm_mem u_perm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (perm_req),
        .o_rdata (perm_rd)
    );

    assign in_key_index = s_axis_tdata[7:0];
    assign in_value     = s_axis_tdata[15:8];
    assign out_free     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) || ((r_state == ST_DW) && out_free);
    assign in_acc       = s_axis_tvalid && s_axis_tready;

    assign key_len_eff = (r_key_len == '0) ? BYTE_W'(1) : r_key_len;
    assign ki_next     = (BYTE_W'(r_ki + 8'd1) == key_len_eff) ? '0 : BYTE_W'(r_ki + 8'd1);
    assign acc_n       = BYTE_W'(r_acc + perm_rd + r_kq);
    assign j_n         = BYTE_W'(r_j + perm_rd);
    assign t_n         = BYTE_W'(r_a + perm_rd);
    // entry j is written back only in the output cycle
    assign ks          = (r_t == r_j) ? r_a : perm_rd;

    always_comb begin
        perm_req  = '0;
        key_re    = 1'b0;
        key_raddr = r_ki;
        case (r_state)
            ST_K0: begin
                perm_req.re    = 1'b1;
                perm_req.raddr = r_k;
                key_re         = 1'b1;
            end
            ST_K1: begin
                perm_req.re    = 1'b1;
                perm_req.raddr = acc_n;
            end
            ST_K2: begin
                perm_req.we    = 1'b1;
                perm_req.waddr = r_k;
                perm_req.wdata = perm_rd;
            end
            ST_K3: begin
                perm_req.we    = 1'b1;
                perm_req.waddr = r_acc;
                perm_req.wdata = r_a;
                if (r_k != LAST_STEP) begin
                    perm_req.re    = 1'b1;
                    perm_req.raddr = BYTE_W'(r_k + 8'd1);
                    key_re         = 1'b1;
                    key_raddr      = ki_next;
                end
            end
            ST_D1: begin
                perm_req.re    = 1'b1;
                perm_req.raddr = j_n;
            end
            ST_D2: begin
                perm_req.we    = 1'b1;
                perm_req.waddr = r_i;
                perm_req.wdata = perm_rd;
                perm_req.re    = 1'b1;
                perm_req.raddr = t_n;
            end
            ST_DW: begin
                if (out_free) begin
                    perm_req.we    = 1'b1;
                    perm_req.waddr = r_j;
                    perm_req.wdata = r_a;
                end
            end
            default: begin
            end
        endcase
        if (in_acc) begin
            case (s_axis_tuser)
                MODE_DATA: begin
                    perm_req.re    = 1'b1;
                    perm_req.raddr = BYTE_W'(r_i + 8'd1);
                end
                MODE_REKEY: begin
                    perm_req.clr = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (s_axis_tuser == MODE_KEY_LOAD) && (in_key_index != KEY_END)) begin
            r_key_mem[in_key_index] <= in_value;
        end
        if (key_re) begin
            r_kq <= r_key_mem[key_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_key_len   <= BYTE_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_key_len <= i_cfg_wdata;
            end

            if ((r_state == ST_DW) && out_free) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= r_val ^ ks;
                r_out_last  <= r_last;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_D1: begin
                    r_a     <= perm_rd;
                    r_j     <= j_n;
                    r_state <= ST_D2;
                end
                ST_D2: begin
                    r_t     <= t_n;
                    r_state <= ST_DW;
                end
                ST_DW: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_K0: begin
                    r_state <= ST_K1;
                end
                ST_K1: begin
                    r_a     <= perm_rd;
                    r_acc   <= acc_n;
                    r_state <= ST_K2;
                end
                ST_K2: begin
                    r_state <= ST_K3;
                end
                ST_K3: begin
                    if (r_k == LAST_STEP) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_k     <= BYTE_W'(r_k + 8'd1);
                        r_ki    <= ki_next;
                        r_state <= ST_K1;
                    end
                end
                default: begin
                end
            endcase

            if (in_acc) begin
                case (s_axis_tuser)
                    MODE_REKEY: begin
                        r_k     <= '0;
                        r_ki    <= '0;
                        r_acc   <= '0;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_state <= ST_K0;
                    end
                    MODE_DATA: begin
                        r_i     <= BYTE_W'(r_i + 8'd1);
                        r_val   <= in_value;
                        r_last  <= s_axis_tlast;
                        r_state <= ST_D1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;

endmodule

@@ rtl/core/rc4_core_sva.sv @@
// port-level checker for rc4_stream_cipher_core, bound to the top level
// depends on rc4_pkg and rc4_stream_cipher_core_macros.svh
`include "rc4_stream_cipher_core_macros.svh"

module rc4_core_sva (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast
);
    import rc4_pkg::*;

    logic in_beat;

    assign in_beat  = s_axis_tvalid && s_axis_tready;

    `RC4_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output beat dropped or changed while stalled")

    `RC4_ASSERT_NEXT(a_rekey_busy, in_beat && (s_axis_tuser == MODE_REKEY), !s_axis_tready, "input taken during key schedule")

    `RC4_ASSERT_NEXT(a_data_busy1, in_beat && (s_axis_tuser == MODE_DATA), !s_axis_tready, "input taken one cycle after data beat")

    `RC4_ASSERT_LATER(a_data_busy2, in_beat && (s_axis_tuser == MODE_DATA), !s_axis_tready, "input taken two cycles after data beat")

    `RC4_ASSERT_NEXT(a_key_load_ready, in_beat && (s_axis_tuser == MODE_KEY_LOAD), s_axis_tready, "not ready after key byte load")

endmodule

bind rc4_stream_cipher_core rc4_core_sva u_rc4_core_sva (.*);

@@ dv/tb_top.sv @@
// testbench for rc4_stream_cipher_core: a streaming driver and a checking monitor around
// a cycle-free rc4 predictor, with key loads, rekeys and cipher beats over many key lengths
// depends on rc4_pkg and the rc4_stream_cipher_core rtl
module tb_top;

    import rc4_pkg::*;

    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam int         SETTLE_CYCLES = 800;
    localparam int         CYCLE_LIMIT   = 600000;
    localparam int         PHASE_COUNT   = 12;
    localparam int         PHASE_ITEMS   = 125;

    typedef struct {
        logic [1:0] mode;
        logic [7:0] kidx;
        logic [7:0] val;
        logic       last_f;
    } t_stim_beat;

    typedef struct {
        logic [7:0] cipher;
        logic       last_f;
    } t_cipher_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_wdata = 8'd0;
    logic        drv_valid = 1'b0;
    logic [15:0] drv_tdata = 16'd0;
    logic [1:0]  drv_tuser = 2'd0;
    logic        drv_tlast = 1'b0;
    logic        rx_ready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    // predictor state
    logic [7:0]  perm_tab [PERM_DEPTH];
    logic [7:0]  key_mem [KEY_DEPTH];
    logic [7:0]  step_i;
    logic [7:0]  step_j;
    logic [7:0]  key_len_q;

    t_stim_beat   pending_q [$];
    t_cipher_beat cipher_due_q [$];
    t_stim_beat   nxt_beat;
    t_cipher_beat due_beat;

    logic        in_fired = 1'b0;
    logic        calm = 1'b0;
    int          gap_left = 0;
    int          burst_left = 1;
    int          stall_left = 0;
    int          cyc_cnt = 0;
    int          err_cnt = 0;
    int          n_checked = 0;
    int          n_rekey = 0;
    int          n_keyload = 0;
    int          n_ignored = 0;
    int          n_cfg = 0;
    int          gen_items = 0;
    logic [7:0]  gen_key_len = 8'd1;
    bit          gen_key_written [KEY_DEPTH];

    rc4_stream_cipher_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (drv_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (drv_tdata),     // [7:0] key_index, [15:8] value
        .s_axis_tuser  (drv_tuser),     // [1:0] mode
        .s_axis_tlast  (drv_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (rx_ready),
        .m_axis_tdata  (m_axis_tdata),  // [7:0] out_byte
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void note_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("mismatch %0d at cycle %0d: %s", err_cnt, cyc_cnt, msg);
        end
    endfunction

    function automatic void rc4_predict(input logic [1:0] mode, input logic [7:0] kidx,
                                        input logic [7:0] val, input logic last_f);
        int          len;
        int          ki;
        logic [7:0]  acc;
        logic [7:0]  tmp;
        logic [7:0]  kb;
        logic [7:0]  sidx;
        t_cipher_beat beat;
        case (mode)
            MODE_KEY_LOAD: begin
                if (kidx < KEY_DEPTH) begin
                    key_mem[kidx] = val;
                    n_keyload++;
                end else begin
                    n_ignored++;
                end
            end
            MODE_REKEY: begin
                len = (key_len_q == 8'd0) ? 1 : int'(key_len_q);
                for (int k = 0; k < PERM_DEPTH; k++) begin
                    perm_tab[k] = 8'(k);
                end
                acc = 8'd0;
                for (int k = 0; k < PERM_DEPTH; k++) begin
                    ki = k % len;
                    kb = (ki < KEY_DEPTH) ? key_mem[ki] : 8'd0;
                    acc = acc + perm_tab[k] + kb;
                    tmp = perm_tab[k];
                    perm_tab[k] = perm_tab[acc];
                    perm_tab[acc] = tmp;
                end
                step_i = 8'd0;
                step_j = 8'd0;
                n_rekey++;
            end
            MODE_DATA: begin
                step_i = step_i + 8'd1;
                step_j = step_j + perm_tab[step_i];
                tmp = perm_tab[step_i];
                perm_tab[step_i] = perm_tab[step_j];
                perm_tab[step_j] = tmp;
                sidx = perm_tab[step_i] + perm_tab[step_j];
                beat.cipher = val ^ perm_tab[sidx];
                beat.last_f = last_f;
                cipher_due_q.push_back(beat);
            end
            default: begin
                n_ignored++;
            end
        endcase
    endfunction

    // monitor: predicts on accepted input beats, checks accepted output beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_fired <= 1'b0;
            for (int k = 0; k < PERM_DEPTH; k++) begin
                perm_tab[k] = 8'(k);
            end
            step_i = 8'd0;
            step_j = 8'd0;
            key_len_q = 8'd1;
        end else begin
            in_fired <= drv_valid && s_axis_tready;
            if (i_cfg_we) begin
                key_len_q = i_cfg_wdata;
            end
            if (drv_valid && s_axis_tready) begin
                rc4_predict(drv_tuser, drv_tdata[7:0], drv_tdata[15:8], drv_tlast);
            end
            if (m_axis_tvalid && rx_ready) begin
                if (cipher_due_q.size() == 0) begin
                    note_error($sformatf("output beat %02h last %0b with none expected",
                                         m_axis_tdata, m_axis_tlast));
                end else begin
                    due_beat = cipher_due_q.pop_front();
                    if (m_axis_tdata !== due_beat.cipher) begin
                        note_error($sformatf("data expected %02h actual %02h",
                                             due_beat.cipher, m_axis_tdata));
                    end
                    if (m_axis_tlast !== due_beat.last_f) begin
                        note_error($sformatf("last expected %0b actual %0b",
                                             due_beat.last_f, m_axis_tlast));
                    end
                    n_checked++;
                end
            end
        end
    end

    // driver: bursts of beats with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else if (!drv_valid || in_fired) begin
            if (gap_left != 0 && !calm) begin
                gap_left <= gap_left - 1;
                drv_valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
                nxt_beat = pending_q.pop_front();
                drv_valid <= 1'b1;
                drv_tdata <= {nxt_beat.val, nxt_beat.kidx};
                drv_tuser <= nxt_beat.mode;
                drv_tlast <= nxt_beat.last_f;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // receiver stalls, now and then for long
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rx_ready <= 1'b0;
        end else if (calm || stall_left == 0) begin
            rx_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) begin
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(1, 4);
            end
        end else begin
            rx_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic queue_beat(input logic [1:0] mode, input logic [7:0] kidx,
                              input logic [7:0] val, input logic last_f);
        t_stim_beat sb;
        sb.mode = mode;
        sb.kidx = kidx;
        sb.val = val;
        sb.last_f = last_f;
        pending_q.push_back(sb);
        if (mode == MODE_KEY_LOAD && kidx < KEY_DEPTH) begin
            gen_key_written[kidx] = 1'b1;
        end
        if (mode != MODE_UNUSED && !(mode == MODE_KEY_LOAD && kidx >= KEY_DEPTH)) begin
            gen_items++;
        end
    endtask

    // every key byte the schedule reads must have been loaded first
    task automatic queue_rekey();
        int n;
        int extra;
        n = (gen_key_len == 8'd0) ? 1 : int'(gen_key_len);
        for (int k = 0; k < n; k++) begin
            if (!gen_key_written[k]) begin
                queue_beat(MODE_KEY_LOAD, 8'(k), 8'($urandom), 1'($urandom));
            end
        end
        extra = $urandom_range(0, 6);
        for (int k = 0; k < extra; k++) begin
            queue_beat(MODE_KEY_LOAD, 8'($urandom_range(0, n - 1)), 8'($urandom),
                       1'($urandom));
        end
        queue_beat(MODE_REKEY, 8'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic wait_drained();
        while (!(pending_q.size() == 0 && !drv_valid && cipher_due_q.size() == 0)) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_key_len(input logic [7:0] len);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= len;
        gen_key_len = len;
        n_cfg++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int          r;
        int          target;
        int          half;
        bit          mid_done;
        logic [7:0]  klen;
        for (int k = 0; k < KEY_DEPTH; k++) begin
            gen_key_written[k] = 1'b0;
        end
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset permutation, ignored beats, key length of one, extremes
        queue_beat(MODE_DATA, 8'h00, 8'h00, 1'b0);
        queue_beat(MODE_DATA, 8'hFF, 8'hFF, 1'b1);
        queue_beat(MODE_UNUSED, 8'hFF, 8'hFF, 1'b1);
        queue_beat(MODE_KEY_LOAD, 8'hFF, 8'hAA, 1'b1);
        queue_beat(MODE_KEY_LOAD, 8'h00, 8'hFF, 1'b0);
        queue_beat(MODE_REKEY, 8'h00, 8'h00, 1'b0);
        queue_beat(MODE_DATA, 8'h12, 8'hFF, 1'b0);
        queue_beat(MODE_DATA, 8'hFF, 8'h00, 1'b1);
        queue_beat(MODE_KEY_LOAD, 8'hFE, 8'h00, 1'b1);
        queue_beat(MODE_KEY_LOAD, 8'h01, 8'h5A, 1'b0);
        queue_beat(MODE_UNUSED, 8'h00, 8'h00, 1'b0);
        queue_beat(MODE_REKEY, 8'hFF, 8'hFF, 1'b1);
        queue_beat(MODE_DATA, 8'h00, 8'hA5, 1'b1);
        queue_beat(MODE_DATA, 8'h55, 8'h00, 1'b0);

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0:       klen = 8'd0;
                1:       klen = 8'd255;
                2:       klen = 8'd1;
                3:       klen = 8'd2;
                4:       klen = 8'd128;
                5:       klen = 8'd3;
                default: klen = 8'($urandom_range(0, 255));
            endcase
            write_key_len(klen);
            calm = (ph % 4 == 2);
            queue_rekey();
            target = gen_items + PHASE_ITEMS;
            half = gen_items + PHASE_ITEMS / 2;
            mid_done = 1'b0;
            while (gen_items < target) begin
                if (!mid_done && gen_items >= half) begin
                    wait_drained();
                    mid_done = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 76) begin
                    queue_beat(MODE_DATA, 8'($urandom), 8'($urandom),
                               ($urandom_range(0, 7) == 0));
                end else if (r < 82) begin
                    queue_beat(MODE_DATA, 8'($urandom), ($urandom_range(0, 1) != 0) ? 8'hFF
                               : 8'h00, 1'($urandom));
                end else if (r < 89) begin
                    queue_beat(MODE_KEY_LOAD, 8'($urandom_range(0, 255)), 8'($urandom),
                               1'($urandom));
                end else if (r < 92) begin
                    queue_beat(MODE_UNUSED, 8'($urandom), 8'($urandom), 1'($urandom));
                end else if (r < 95) begin
                    queue_rekey();
                end else begin
                    queue_beat(MODE_DATA, 8'($urandom), 8'($urandom), 1'b1);
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("run covered %0d cipher beats checked, %0d rekeys, %0d key loads",
                 n_checked, n_rekey, n_keyload);
        $display("with %0d ignored beats over %0d key length settings, %0d errors",
                 n_ignored, n_cfg, err_cnt);
        if (err_cnt == 0 && cipher_due_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
